FILE: hw/rtl/tlcb_pkg.sv
package tlcb_pkg;

   // Grid geometry
   localparam int NUM_BLOCKS      = 8;
   localparam int CORES_PER_BLOCK = 4;
   localparam int TOTAL_CORES     = NUM_BLOCKS * CORES_PER_BLOCK;

   // Field widths of the transactions
   localparam int CMD_W      = 1;
   localparam int BLOCK_ID_W = 3;
   localparam int CORE_ID_W  = 2;
   localparam int ARRIVED_W  = 6;

   // Internal index and counter widths
   localparam int BLK_IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CORE_IDX_W = (CORES_PER_BLOCK > 1) ? $clog2(CORES_PER_BLOCK) : 1;
   localparam int GBL_IDX_W  = (TOTAL_CORES > 1) ? $clog2(TOTAL_CORES) : 1;
   localparam int BCNT_W     = $clog2(CORES_PER_BLOCK + 1);
   localparam int GCNT_W     = $clog2(TOTAL_CORES + 1);

   // Decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Scope codes
   localparam logic [CMD_W-1:0] SCOPE_BLOCK  = 1'b0;
   localparam logic [CMD_W-1:0] SCOPE_GLOBAL = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [BLOCK_ID_W-1:0] block_id;
      logic [CORE_ID_W-1:0]  core_id;
   } req_type;

   typedef struct packed {
      logic [ARRIVED_W-1:0]  arrived_count;
      logic                  release_res;
      logic [CMD_W-1:0]      scope_echo;
      logic [BLOCK_ID_W-1:0] block_echo;
   } rsp_type;

   // Classified arrival, as handed from front to back
   typedef struct packed {
      logic [CMD_W-1:0]      scope;
      logic                  blk_ok;
      logic                  core_ok;
      logic [BLK_IDX_W-1:0]  blk_idx;
      logic [CORE_IDX_W-1:0] core_idx;
      logic [BLOCK_ID_W-1:0] block_id;
   } op_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

FILE: hw/rtl/tlcb_front.sv
module tlcb_front import tlcb_pkg::*; (
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             push,
   output op_type           push_op
);

   logic blk_ok;
   logic core_ok;

   // Range-check the indexes of the arrival
   assign blk_ok  = int'(req_data.block_id) < NUM_BLOCKS;
   assign core_ok = int'(req_data.core_id) < CORES_PER_BLOCK;

   // Build the classified operation for the back part
   always_comb begin
      push_op          = '0;
      push_op.scope    = req_data.cmd;
      push_op.blk_ok   = blk_ok;
      push_op.core_ok  = core_ok;
      push_op.blk_idx  = BLK_IDX_W'(req_data.block_id);
      push_op.core_idx = CORE_IDX_W'(req_data.core_id);
      push_op.block_id = req_data.block_id;
   end

   // Hold requests while the queue is full
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

endmodule

FILE: hw/rtl/tlcb_queue.sv
module tlcb_queue import tlcb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  op_type           push_op,
   input  logic             pop,
   output op_type           head_op,
   output queue_status_type status
);

   op_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign head_op          = entries_ff[rd_ptr_ff];
   assign status.full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.not_empty = count_ff != '0;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed operation
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: hw/rtl/tlcb_back.sv
module tlcb_back import tlcb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  op_type           head_op,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   logic [CORES_PER_BLOCK-1:0] blk_mask_ff [NUM_BLOCKS];
   logic [CORES_PER_BLOCK-1:0] blk_mask_cur;
   logic [CORES_PER_BLOCK-1:0] blk_mask_new;
   logic [CORES_PER_BLOCK-1:0] core_bit;
   logic [BCNT_W-1:0]          blk_cnt;
   logic                       blk_release;

   logic [TOTAL_CORES-1:0]     gbl_mask_ff;
   logic [GCNT_W-1:0]          gbl_cnt_ff;
   logic [GCNT_W-1:0]          gbl_cnt_in;
   logic [GBL_IDX_W-1:0]       gbl_idx;
   logic                       gbl_ok;
   logic                       gbl_release;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   rsp_type                    rsp_data_ff;
   rsp_type                    rsp_data_in;

   // Take the queue head when the output register is free or being drained
   assign pop = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);

   // Block scope: set the core bit and count the block mask
   always_comb begin
      core_bit = '0;
      if (head_op.core_ok) begin
         core_bit[head_op.core_idx] = 1'b1;
      end
      blk_mask_cur = blk_mask_ff[head_op.blk_idx];
      blk_mask_new = blk_mask_cur | core_bit;
      blk_cnt      = '0;
      for (int i = 0; i < CORES_PER_BLOCK; i++) begin
         blk_cnt = blk_cnt + BCNT_W'(blk_mask_new[i]);
      end
   end

   assign blk_release = head_op.blk_ok && head_op.core_ok
                        && (blk_cnt == BCNT_W'(CORES_PER_BLOCK));

   // Global scope: running count, grows only on a first arrival
   assign gbl_ok  = head_op.blk_ok && head_op.core_ok;
   assign gbl_idx = GBL_IDX_W'(int'(head_op.blk_idx) * CORES_PER_BLOCK
                               + int'(head_op.core_idx));

   always_comb begin
      gbl_cnt_in = gbl_cnt_ff;
      if (gbl_ok && !gbl_mask_ff[gbl_idx]) begin
         gbl_cnt_in = gbl_cnt_ff + 1'b1;
      end
   end

   assign gbl_release = gbl_ok && (gbl_cnt_in == GCNT_W'(TOTAL_CORES));

   // Assemble the result transaction
   always_comb begin
      rsp_data_in            = '0;
      rsp_data_in.scope_echo = head_op.scope;
      rsp_data_in.block_echo = head_op.block_id;
      if (head_op.scope == SCOPE_GLOBAL) begin
         rsp_data_in.arrived_count = ARRIVED_W'(gbl_cnt_in);
         rsp_data_in.release_res   = gbl_release;
      end else if (head_op.blk_ok) begin
         rsp_data_in.arrived_count = ARRIVED_W'(blk_cnt);
         rsp_data_in.release_res   = blk_release;
      end
   end

   // Output register: load on pop, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Update arrival state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            blk_mask_ff[b] <= '0;
         end
         gbl_mask_ff  <= '0;
         gbl_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop && head_op.scope == SCOPE_BLOCK && head_op.blk_ok) begin
            blk_mask_ff[head_op.blk_idx] <= blk_release ? '0 : blk_mask_new;
         end
         if (pop && head_op.scope == SCOPE_GLOBAL && gbl_ok) begin
            if (gbl_release) begin
               gbl_mask_ff <= '0;
               gbl_cnt_ff  <= '0;
            end else begin
               gbl_mask_ff[gbl_idx] <= 1'b1;
               gbl_cnt_ff           <= gbl_cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/two_level_core_barrier.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_type: cmd, block_id, core_id
// rsp_      out        rsp_valid/rsp_stall  rsp_type: arrived_count, release_res,
//                                           scope_echo, block_echo
//
// One arrival per cycle sustained while req_stall is low; a taken request is queued,
// then popped as its result is loaded into the output register feeding rsp_data.
// The mask update, bit count and full compare run combinationally in the back stage.
// Synchronous reset clears all block masks, the global mask and its count.
// A two-entry queue parts the front from the back: req_stall rises only when it
// is full; with back-to-back requests that is in the cycle after rsp_stall starts
// holding a valid result, and at most three transactions are held in all.
module two_level_core_barrier import tlcb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   op_type           push_op;
   op_type           head_op;

   tlcb_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_op   (push_op)
   );

   tlcb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .status  (q_status)
   );

   tlcb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_op   (head_op),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/tlcb_checker.sv
module tlcb_checker import tlcb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // No result leaves right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A block release reports a full block
   a_block_release_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.release_res && rsp_data.scope_echo == SCOPE_BLOCK
      |-> rsp_data.arrived_count == ARRIVED_W'(CORES_PER_BLOCK))
      else $error("block release without full count");

   // A global release reports the whole grid
   a_global_release_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.release_res && rsp_data.scope_echo == SCOPE_GLOBAL
      |-> rsp_data.arrived_count == ARRIVED_W'(TOTAL_CORES))
      else $error("global release without full count");

   // A block count never exceeds the block size
   a_block_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.scope_echo == SCOPE_BLOCK
      |-> int'(rsp_data.arrived_count) <= CORES_PER_BLOCK)
      else $error("block count above block size");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind two_level_core_barrier tlcb_checker u_tlcb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
